// ----- sv/spie_pkg.sv -----
// Package: payload types and status codes for the shortest path engine.
package spie_pkg;

	localparam int NODE_BITS   = 6;
	localparam int WEIGHT_W    = 16;
	localparam int DIST_W      = 32;
	localparam int CNT_BITS    = 7;

	typedef enum logic [1:0] {
		KIND_ADD     = 2'd0,
		KIND_ADD_RLX = 2'd1,
		KIND_RUN     = 2'd2,
		KIND_READ    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BAD_NODE = 2'd2,
		ST_RSVD     = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [NODE_BITS-1:0] node_a;
		logic [NODE_BITS-1:0] node_b;
		logic [WEIGHT_W-1:0]  weight;
	} item_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [DIST_W-1:0]    distance;
		logic                 reachable;
		logic [NODE_BITS-1:0] parent;
		logic                 has_parent;
	} result_t;

endpackage

// ----- sv/spie_edge_mem.sv -----
// Edge table memory: one write port, one registered read port.
module spie_edge_mem #(
	parameter int DEPTH = 512,
	parameter int AW    = 9,
	parameter int DW    = 28
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// synchronous write and read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- sv/spie_node_mem.sv -----
// Node memory: distance, parent and parent-valid per node, registered read.
module spie_node_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 39
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// synchronous write and read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- sv/shortest_path_incremental_edge.sv -----
// Shortest path engine top level: sequencer over the node and edge memories.
// One item at a time: the input is stalled from a transfer until its result has been taken.
// An add or a rejected item passes through decode and result before its result shows; a
// read, or a relaxing add from an unreachable tail, passes through decode, a node memory
// read and result. A run first clears the node memory (one node per cycle, over all
// MAX_NODES nodes) and writes the source. A run or a relaxing add from a reachable tail then
// repeats a search for each settlement. The search scans the active nodes for the least
// pending distance, with an added read step for a pending one, plus a closing step. It then
// scans the stored edges, reading each one, with one node memory read-modify-write for an
// edge that leaves the settled node and whose head is an active node. After reset a clearing
// pass goes through the node memory before the first item is taken;
// configuration writes are taken at any time.
module shortest_path_incremental_edge #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  spie_pkg::item_t          in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output spie_pkg::result_t        out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [spie_pkg::CNT_BITS-1:0] cfg_data
);

	localparam int NB   = spie_pkg::NODE_BITS;
	localparam int DW   = spie_pkg::DIST_W;
	localparam int WW   = spie_pkg::WEIGHT_W;
	localparam int NAW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int NCW  = $clog2(MAX_NODES + 1);
	localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EFW  = $clog2(MAX_EDGES + 1);
	localparam int EDW  = 2 * NB + WW;
	localparam int NDW  = DW + NB + 1;
	localparam logic [DW-1:0] INF = '1;

	typedef enum logic [11:0] {
		S_CLR    = 12'b000000000001,
		S_IDLE   = 12'b000000000010,
		S_RDRD   = 12'b000000000100,
		S_RDWT   = 12'b000000001000,
		S_ACHK   = 12'b000000010000,
		S_SCAN   = 12'b000000100000,
		S_SCANW  = 12'b000001000000,
		S_EDGE   = 12'b000010000000,
		S_EDGEW  = 12'b000100000000,
		S_HEAD   = 12'b001000000000,
		S_HEADW  = 12'b010000000000,
		S_OUT    = 12'b100000000000
	} state_t;

	state_t state_q;
	spie_pkg::item_t item_q;
	spie_pkg::result_t res_q;
	logic out_valid_q;
	logic [spie_pkg::CNT_BITS-1:0] ncount_q;
	logic [EFW-1:0] fill_q;
	logic [MAX_NODES-1:0] pend_q;
	logic [NAW:0] idx_q;
	logic [EFW-1:0] eidx_q;
	logic [NAW-1:0] best_q;
	logic [DW-1:0] best_d_q;
	logic found_q;
	logic [EDW-1:0] edge_q;

	// memory ports
	logic nm_we;
	logic [NAW-1:0] nm_wa, nm_ra;
	logic [NDW-1:0] nm_wd, nm_rd;
	logic nm_we_f;
	logic [NAW-1:0] nm_wa_f;
	logic [NDW-1:0] nm_wd_f;
	logic em_we;
	logic [EAW-1:0] em_wa, em_ra;
	logic [EDW-1:0] em_wd, em_rd;

	spie_node_mem #(.DEPTH(MAX_NODES), .AW(NAW), .DW(NDW)) u_node (
		.clk(clk), .wr_en(nm_we_f), .wr_addr(nm_wa_f), .wr_data(nm_wd_f),
		.rd_addr(nm_ra), .rd_data(nm_rd)
	);

	spie_edge_mem #(.DEPTH(MAX_EDGES), .AW(EAW), .DW(EDW)) u_edge (
		.clk(clk), .wr_en(em_we), .wr_addr(em_wa), .wr_data(em_wd),
		.rd_addr(em_ra), .rd_data(em_rd)
	);

	// active node count, clipped
	logic [NCW:0] cnt;
	always_comb begin
		if ({1'b0, ncount_q} > (spie_pkg::CNT_BITS+1)'(MAX_NODES)) begin
			cnt = (NCW+1)'(MAX_NODES);
		end else begin
			cnt = (NCW+1)'(ncount_q);
		end
	end

	logic a_bad, b_bad;
	assign a_bad = (NCW+1)'(item_q.node_a) >= cnt;
	assign b_bad = (NCW+1)'(item_q.node_b) >= cnt;

	// decode checks: index range first, then table room
	logic is_add, room, add_ok;
	spie_pkg::status_t dec_st;
	assign is_add = (item_q.kind == spie_pkg::KIND_ADD) ||
		(item_q.kind == spie_pkg::KIND_ADD_RLX);
	assign room   = fill_q < EFW'(MAX_EDGES);
	assign add_ok = is_add && !a_bad && !b_bad && room;
	always_comb begin
		dec_st = spie_pkg::ST_OK;
		if (a_bad || (is_add && b_bad)) begin
			dec_st = spie_pkg::ST_BAD_NODE;
		end else if (is_add && !room) begin
			dec_st = spie_pkg::ST_FULL;
		end
	end

	// node memory fields
	logic [DW-1:0] rd_dist;
	logic [NB-1:0] rd_par;
	logic rd_pv;
	assign rd_dist = nm_rd[NDW-1 -: DW];
	assign rd_par  = nm_rd[NB:1];
	assign rd_pv   = nm_rd[0];

	// edge fields
	logic [NB-1:0] e_tail, e_head;
	logic [WW-1:0] e_w;
	assign e_tail = edge_q[EDW-1 -: NB];
	assign e_head = edge_q[WW +: NB];
	assign e_w    = edge_q[WW-1:0];

	logic [DW-1:0] diff;
	logic relax;
	assign diff  = rd_dist - best_d_q;
	assign relax = (rd_dist > best_d_q) && (DW'(e_w) < diff);

	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;
	assign cfg_ready = 1'b1;

	// memory control
	always_comb begin
		nm_we = 1'b0;
		nm_wa = idx_q[NAW-1:0];
		nm_wd = {INF, {NB{1'b0}}, 1'b0};
		nm_ra = idx_q[NAW-1:0];
		em_we = 1'b0;
		em_wa = fill_q[EAW-1:0];
		em_wd = {item_q.node_a, item_q.node_b, item_q.weight};
		em_ra = eidx_q[EAW-1:0];
		unique case (state_q)
			S_CLR: nm_we = 1'b1;
			S_RDRD: begin
				nm_ra = NAW'(item_q.node_a);
				em_we = add_ok;
			end
			S_HEAD: nm_ra = NAW'(e_head);
			S_HEADW: begin
				nm_wa = NAW'(e_head);
				nm_wd = {best_d_q + DW'(e_w), NB'(best_q), 1'b1};
				nm_we = relax;
			end
			default: begin
			end
		endcase
	end

	// run source write: done in a dedicated state (S_ACHK) using a flag
	logic src_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
			ncount_q    <= spie_pkg::CNT_BITS'(64);
			fill_q      <= '0;
			pend_q      <= '0;
			idx_q       <= '0;
			eidx_q      <= '0;
			found_q     <= 1'b0;
			src_q       <= 1'b0;
			item_q      <= '0;
			res_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ncount_q <= cfg_data;
			end
			// result held until its transfer
			out_valid_q <= (state_q == S_OUT) || (out_valid_q && out_stall);
			unique case (state_q)
				// clearing pass over node memory
				S_CLR: begin
					if (idx_q == (NAW+1)'(MAX_NODES - 1)) begin
						idx_q <= '0;
						if (src_q) begin
							src_q   <= 1'b0;
							pend_q  <= {{(MAX_NODES-1){1'b0}}, 1'b1} << item_q.node_a;
							state_q <= S_ACHK;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid && !out_valid_q) begin
						item_q  <= in_data;
						state_q <= S_RDRD;
					end
				end
				// decode: checks, edge store, read of node_a
				S_RDRD: begin
					res_q <= {dec_st, {(DW+NB+2){1'b0}}};
					if (dec_st != spie_pkg::ST_OK) begin
						state_q <= S_OUT;
					end else begin
						unique case (spie_pkg::kind_t'(item_q.kind))
							spie_pkg::KIND_ADD: begin
								fill_q  <= fill_q + 1'b1;
								state_q <= S_OUT;
							end
							spie_pkg::KIND_ADD_RLX: begin
								fill_q  <= fill_q + 1'b1;
								state_q <= S_RDWT;
							end
							spie_pkg::KIND_RUN: begin
								src_q   <= 1'b1;
								idx_q   <= '0;
								state_q <= S_CLR;
							end
							spie_pkg::KIND_READ: state_q <= S_RDWT;
							default: state_q <= S_OUT;
						endcase
					end
				end
				// node_a data ready
				S_RDWT: begin
					if (item_q.kind == spie_pkg::KIND_READ) begin
						res_q   <= {spie_pkg::ST_OK, rd_dist, rd_dist != INF,
							rd_par & {NB{rd_pv}}, rd_pv};
						state_q <= S_OUT;
					end else if (rd_dist != INF) begin
						pend_q[NAW'(item_q.node_a)] <= 1'b1;
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_OUT;
					end
				end
				// run source: distance zero written here
				S_ACHK: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					state_q <= S_SCAN;
				end
				// min search: issue read
				S_SCAN: begin
					if (idx_q >= (NAW+1)'(cnt)) begin
						if (found_q) begin
							pend_q[best_q] <= 1'b0;
							eidx_q  <= '0;
							state_q <= S_EDGE;
						end else begin
							state_q <= S_OUT;
						end
					end else if (!pend_q[idx_q[NAW-1:0]]) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_SCANW;
					end
				end
				S_SCANW: begin
					if (!found_q || rd_dist <= best_d_q) begin
						best_q   <= idx_q[NAW-1:0];
						best_d_q <= rd_dist;
						found_q  <= 1'b1;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= S_SCAN;
				end
				// edge scan
				S_EDGE: begin
					if (eidx_q >= fill_q) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_EDGEW;
					end
				end
				S_EDGEW: begin
					edge_q <= em_rd;
					if (em_rd[EDW-1 -: NB] == NB'(best_q) &&
						(NCW+1)'(em_rd[WW +: NB]) < cnt) begin
						state_q <= S_HEAD;
					end else begin
						eidx_q  <= eidx_q + 1'b1;
						state_q <= S_EDGE;
					end
				end
				S_HEAD: state_q <= S_HEADW;
				S_HEADW: begin
					if (relax) begin
						pend_q[NAW'(e_head)] <= 1'b1;
					end
					eidx_q  <= eidx_q + 1'b1;
					state_q <= S_EDGE;
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// source distance write overrides the default port drive
	logic src_wr;
	assign src_wr = (state_q == S_ACHK);
	assign nm_we_f = src_wr | nm_we;
	assign nm_wa_f = src_wr ? NAW'(item_q.node_a) : nm_wa;
	assign nm_wd_f = src_wr ? {{DW{1'b0}}, {NB{1'b0}}, 1'b0} : nm_wd;

	// a result is only shown while the sequencer is idle
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_IDLE)
		else $error("result valid in unexpected state");

	// fill count never passes the table depth
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= EFW'(MAX_EDGES))
		else $error("edge fill overflow");

	// a transfer into the block only from idle
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_RDRD)
		else $error("accept did not start decode");

endmodule

// ----- tb/tb_shortest_path_incremental_edge.sv -----
// Testbench for the shortest path engine: directed table, random graphs, scoreboard.
module tb_shortest_path_incremental_edge;

	localparam int NNODES = 64;
	localparam int NEDGES = 512;
	localparam logic [31:0] DIST_NONE = 32'hFFFF_FFFF;
	localparam int CYCLE_LIMIT = 30000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	spie_pkg::item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	spie_pkg::result_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [spie_pkg::CNT_BITS-1:0] cfg_data = '0;

	shortest_path_incremental_edge u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow graph state
	logic [6:0] sh_count;
	logic [5:0] sh_tail [NEDGES];
	logic [5:0] sh_head [NEDGES];
	logic [15:0] sh_wt [NEDGES];
	int sh_fill;
	logic [31:0] sh_dist [NNODES];
	logic [5:0] sh_par [NNODES];
	logic sh_has_par [NNODES];
	logic sh_pend [NNODES];

	spie_pkg::result_t pending_results[$];
	int mismatches = 0;
	bit timed_out = 0;
	bit hold_off = 0;
	longint cycles = 0;

	function automatic int live_nodes();
		return (sh_count > NNODES) ? NNODES : int'(sh_count);
	endfunction

	function automatic void clear_nodes();
		for (int i = 0; i < NNODES; i++) begin
			sh_dist[i] = DIST_NONE;
			sh_par[i] = '0;
			sh_has_par[i] = 1'b0;
			sh_pend[i] = 1'b0;
		end
	endfunction

	// Settle pending nodes: least distance first, larger index on ties
	function automatic void settle(int cnt);
		int best;
		bit found;
		logic [31:0] d, cur;
		forever begin
			found = 0;
			best = 0;
			for (int i = 0; i < cnt; i++)
				if (sh_pend[i] && (!found || sh_dist[i] <= sh_dist[best])) begin
					best = i;
					found = 1;
				end
			if (!found) break;
			sh_pend[best] = 1'b0;
			d = sh_dist[best];
			for (int e = 0; e < sh_fill; e++) begin
				if (sh_tail[e] != best || sh_head[e] >= cnt) continue;
				cur = sh_dist[sh_head[e]];
				if (cur > d && {16'd0, sh_wt[e]} < cur - d) begin
					sh_dist[sh_head[e]] = d + sh_wt[e];
					sh_par[sh_head[e]] = best[5:0];
					sh_has_par[sh_head[e]] = 1'b1;
					sh_pend[sh_head[e]] = 1'b1;
				end
			end
		end
	endfunction

	function automatic spie_pkg::result_t path_result(spie_pkg::item_t it);
		spie_pkg::result_t r;
		int cnt;
		r = '0;
		cnt = live_nodes();
		case (spie_pkg::kind_t'(it.kind)) inside
			spie_pkg::KIND_ADD, spie_pkg::KIND_ADD_RLX: begin
				if (it.node_a >= cnt || it.node_b >= cnt) r.status = spie_pkg::ST_BAD_NODE;
				else if (sh_fill >= NEDGES) r.status = spie_pkg::ST_FULL;
				else begin
					sh_tail[sh_fill] = it.node_a;
					sh_head[sh_fill] = it.node_b;
					sh_wt[sh_fill] = it.weight;
					sh_fill++;
					if (it.kind == spie_pkg::KIND_ADD_RLX &&
					    sh_dist[it.node_a] != DIST_NONE) begin
						sh_pend[it.node_a] = 1'b1;
						settle(cnt);
					end
				end
			end
			spie_pkg::KIND_RUN: begin
				if (it.node_a >= cnt) r.status = spie_pkg::ST_BAD_NODE;
				else begin
					clear_nodes();
					sh_dist[it.node_a] = '0;
					sh_pend[it.node_a] = 1'b1;
					settle(cnt);
				end
			end
			default: begin
				if (it.node_a >= cnt) r.status = spie_pkg::ST_BAD_NODE;
				else begin
					r.distance = sh_dist[it.node_a];
					r.reachable = (sh_dist[it.node_a] != DIST_NONE);
					if (sh_has_par[it.node_a]) begin
						r.has_parent = 1'b1;
						r.parent = sh_par[it.node_a];
					end
				end
			end
		endcase
		return r;
	endfunction

	// One transfer on the item channel, predicted on acceptance
	task automatic send_item(spie_pkg::item_t it, bit fixed, spie_pkg::result_t want);
		spie_pkg::result_t p;
		int idle;
		idle = $urandom_range(0, 9);
		if (idle != 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		p = path_result(it);
		pending_results.push_back(fixed ? want : p);
		@(negedge clk);
	endtask

	task automatic write_count(logic [6:0] v);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sh_count = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic spie_pkg::item_t mk(spie_pkg::kind_t k, int a, int b, int w);
		spie_pkg::item_t it;
		it.kind = k;
		it.node_a = a[5:0];
		it.node_b = b[5:0];
		it.weight = w[15:0];
		return it;
	endfunction

	// Result side: random stalls, plus one long hold-off
	initial begin
		int stall_n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) out_stall <= 1'b1;
			else begin
				stall_n = $urandom_range(0, 9);
				if (stall_n != 0) begin
					out_stall <= 1'b1;
					repeat (stall_n) @(negedge clk);
				end
				out_stall <= 1'b0;
			end
		end
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		spie_pkg::result_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", out_data);
			end else begin
				w = pending_results.pop_front();
				if (w.status != out_data.status || w.distance != out_data.distance ||
				    w.reachable != out_data.reachable || w.parent != out_data.parent ||
				    w.has_parent != out_data.has_parent) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", w, out_data);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			timed_out = 1;
			$display("TB_ERROR");
			$finish;
		end
	end

	typedef struct {
		spie_pkg::item_t it;
		bit fixed;
		spie_pkg::result_t want;
	} step_t;

	initial begin
		step_t plan[$];
		spie_pkg::item_t it;
		int n, sel;
		sh_count = 7'd64;
		sh_fill = 0;
		clear_nodes();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset reads, extremes, every kind
		plan.push_back('{mk(spie_pkg::KIND_READ, 0, 0, 0), 1,
			'{spie_pkg::ST_OK, DIST_NONE, 0, 0, 0}});
		plan.push_back('{mk(spie_pkg::KIND_READ, 63, 0, 0), 1,
			'{spie_pkg::ST_OK, DIST_NONE, 0, 0, 0}});
		plan.push_back('{mk(spie_pkg::KIND_ADD_RLX, 5, 6, 3), 1, '0});
		plan.push_back('{mk(spie_pkg::KIND_READ, 6, 0, 0), 1,
			'{spie_pkg::ST_OK, DIST_NONE, 0, 0, 0}});
		plan.push_back('{mk(spie_pkg::KIND_ADD, 0, 63, 65535), 1, '0});
		plan.push_back('{mk(spie_pkg::KIND_ADD, 0, 5, 0), 1, '0});
		plan.push_back('{mk(spie_pkg::KIND_ADD, 63, 6, 1), 1, '0});
		plan.push_back('{mk(spie_pkg::KIND_RUN, 0, 42, 9), 1, '0});
		plan.push_back('{mk(spie_pkg::KIND_READ, 0, 0, 0), 1,
			'{spie_pkg::ST_OK, 32'd0, 1, 0, 0}});
		plan.push_back('{mk(spie_pkg::KIND_READ, 63, 0, 0), 1,
			'{spie_pkg::ST_OK, 32'd65535, 1, 0, 1}});
		plan.push_back('{mk(spie_pkg::KIND_READ, 6, 0, 0), 0, '0});
		plan.push_back('{mk(spie_pkg::KIND_ADD_RLX, 5, 6, 0), 0, '0});
		plan.push_back('{mk(spie_pkg::KIND_READ, 6, 0, 0), 0, '0});
		plan.push_back('{mk(spie_pkg::KIND_ADD, 6, 6, 0), 0, '0});
		plan.push_back('{mk(spie_pkg::KIND_RUN, 63, 0, 0), 0, '0});
		plan.push_back('{mk(spie_pkg::KIND_READ, 6, 0, 0), 0, '0});
		foreach (plan[i]) send_item(plan[i].it, plan[i].fixed, plan[i].want);

		// Node count of one: only node 0 valid
		write_count(7'd1);
		send_item(mk(spie_pkg::KIND_ADD, 0, 1, 4), 1, '{spie_pkg::ST_BAD_NODE, 0, 0, 0, 0});
		send_item(mk(spie_pkg::KIND_RUN, 1, 0, 0), 1, '{spie_pkg::ST_BAD_NODE, 0, 0, 0, 0});
		send_item(mk(spie_pkg::KIND_READ, 1, 0, 0), 1, '{spie_pkg::ST_BAD_NODE, 0, 0, 0, 0});
		send_item(mk(spie_pkg::KIND_RUN, 0, 0, 0), 0, '0);
		send_item(mk(spie_pkg::KIND_READ, 0, 0, 0), 0, '0);
		// Zero and above-range counts
		write_count(7'd0);
		send_item(mk(spie_pkg::KIND_READ, 0, 0, 0), 1, '{spie_pkg::ST_BAD_NODE, 0, 0, 0, 0});
		write_count(7'd127);
		send_item(mk(spie_pkg::KIND_READ, 63, 0, 0), 0, '0);

		// Random phases: mostly small graphs; plain adds and reads, fewer relaxing adds and runs
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_count(7'd8);
				1: write_count(7'($urandom_range(2, 16)));
				2: write_count(7'd64);
				3: write_count(7'($urandom_range(1, 127)));
				default: write_count(7'd12);
			endcase
			n = live_nodes();
			for (int i = 0; i < 22; i++) begin
				sel = $urandom_range(0, 9);
				it.kind = (sel < 4) ? spie_pkg::KIND_ADD : (sel < 6) ? spie_pkg::KIND_ADD_RLX :
				          (sel < 7) ? spie_pkg::KIND_RUN : spie_pkg::KIND_READ;
				if ($urandom_range(0, 11) == 0) begin
					it.node_a = 6'($urandom);
					it.node_b = 6'($urandom);
				end else begin
					it.node_a = 6'($urandom_range(0, (n > 0 ? n : 1) - 1));
					it.node_b = 6'($urandom_range(0, (n > 0 ? n : 1) - 1));
				end
				it.weight = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
				            16'($urandom_range(0, 20));
				send_item(it, 0, '0);
			end
		end
		// Hold-off in a process of its own while items keep coming
		fork
			begin
				hold_off = 1;
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
		join_none
		send_item(mk(spie_pkg::KIND_ADD_RLX, 0, 1, 0), 0, '0);
		send_item(mk(spie_pkg::KIND_RUN, 0, 0, 0), 0, '0);
		for (int i = 0; i < 4; i++) send_item(mk(spie_pkg::KIND_READ, i, 0, 0), 0, '0);
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (mismatches == 0 && !timed_out) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
